// ===== rtl/core/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants, types and codes of the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int unsigned SLOTS      = 128;
  localparam int unsigned POOL_BYTES = 2048;

  localparam int unsigned OFF_W  = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
  localparam int unsigned LEN_W  = OFF_W + 1;
  localparam int unsigned REQ_W  = 16;
  localparam int unsigned SIZE_W = REQ_W + 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned STAT_W = 3;

  localparam logic [LEN_W-1:0] POOL_END = LEN_W'(POOL_BYTES);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SLOT   = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_ZERO      = 3'd4
  } status_e;

  // One table record as seen by the neighboring cells
  typedef struct packed {
    logic             valid;
    logic [OFF_W-1:0] start;
    logic [LEN_W-1:0] len;
  } rec_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              eval;
    logic              is_free;
    logic              ins;
    logic              del;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;
  } ctl_t;

  localparam rec_t REC_ORIGIN = '{valid: 1'b1, start: '0, len: '0};
  localparam rec_t REC_EMPTY  = '{valid: 1'b0, start: '0, len: '0};

endpackage

// ===== rtl/core/ffpa_cell.sv =====
// ----------------------------------------------------------------------------
// ffpa_cell
// One record of the sorted table; tests its gap or range, shifts on update.
// ----------------------------------------------------------------------------
module ffpa_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ffpa_pkg::ctl_t             ctl_i,
  input  ffpa_pkg::rec_t             left_i,
  input  ffpa_pkg::rec_t             right_i,
  input  logic                       sel_le_i,
  input  logic                       sel_lt_i,
  output ffpa_pkg::rec_t             rec_o,
  output logic                       hit_o,
  output logic [ffpa_pkg::OFF_W-1:0] base_o
);
  import ffpa_pkg::*;

  logic             valid_q, valid_d;
  logic [OFF_W-1:0] start_q, start_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             hit_q;
  logic [LEN_W-1:0] base;
  logic [LEN_W-1:0] start_x;
  logic [LEN_W-1:0] gap;
  logic [LEN_W-1:0] room;
  logic [LEN_W-1:0] off_x;
  logic             fit_gap;
  logic             fit_tail;
  logic             in_range;
  logic             hit;

  // gap start is the end of the left neighbor
  assign base    = LEN_W'(left_i.start) + left_i.len;
  assign start_x = LEN_W'(start_q);
  assign gap     = start_x - base;
  assign room    = POOL_END - base;
  assign off_x   = LEN_W'(ctl_i.off);

  assign fit_gap  = (start_x >= base) && (SIZE_W'(gap) >= ctl_i.size);
  assign fit_tail = left_i.valid && (base <= POOL_END) && (ctl_i.size <= SIZE_W'(room));
  assign in_range = (start_x <= off_x) && (off_x < start_x + len_q);

  always_comb begin
    if (ctl_i.is_free) begin
      hit = valid_q && in_range;
    end else begin
      hit = valid_q ? fit_gap : fit_tail;
    end
  end

  always_comb begin
    valid_d = valid_q;
    start_d = start_q;
    len_d   = len_q;
    if (ctl_i.ins) begin
      if (sel_lt_i) begin
        valid_d = left_i.valid;
        start_d = left_i.start;
        len_d   = left_i.len;
      end else if (sel_le_i) begin
        valid_d = 1'b1;
        start_d = base[OFF_W-1:0];
        len_d   = ctl_i.size[LEN_W-1:0];
      end
    end else if (ctl_i.del && sel_le_i) begin
      valid_d = right_i.valid;
      start_d = right_i.start;
      len_d   = right_i.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      len_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      len_q   <= len_d;
      if (ctl_i.eval) begin
        hit_q <= hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
  end

  assign rec_o  = '{valid: valid_q, start: start_q, len: len_q};
  assign hit_o  = hit_q;
  assign base_o = base[OFF_W-1:0];

endmodule

// ===== rtl/core/ffpa_scan.sv =====
// ----------------------------------------------------------------------------
// ffpa_scan
// Prefix OR over the cell hits; picks the first hit and its gap offset.
// ----------------------------------------------------------------------------
module ffpa_scan (
  input  logic [ffpa_pkg::SLOTS-1:0]                      hit_i,
  input  logic [ffpa_pkg::SLOTS-1:0][ffpa_pkg::OFF_W-1:0] base_i,
  output logic [ffpa_pkg::SLOTS-1:0]                      sel_le_o,
  output logic [ffpa_pkg::SLOTS-1:0]                      sel_lt_o,
  output logic                                            found_o,
  output logic [ffpa_pkg::OFF_W-1:0]                      base_o
);
  import ffpa_pkg::*;

  localparam int unsigned LVLS = $clog2(SLOTS);

  logic [LVLS:0][SLOTS-1:0] pre;
  logic [SLOTS-1:0]         first;

  // log-depth prefix OR
  always_comb begin
    pre[0] = hit_i;
    for (int l = 0; l < LVLS; l++) begin
      pre[l+1] = pre[l] | (pre[l] << (1 << l));
    end
  end

  assign sel_le_o = pre[LVLS];
  assign sel_lt_o = {pre[LVLS][SLOTS-2:0], 1'b0};
  assign found_o  = pre[LVLS][SLOTS-1];
  assign first    = sel_le_o & ~sel_lt_o;

  always_comb begin
    base_o = '0;
    for (int i = 0; i < SLOTS; i++) begin
      base_o = base_o | (base_i[i] & {OFF_W{first[i]}});
    end
  end

endmodule

// ===== rtl/core/first_fit_pool_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_core
// First-fit allocator over a byte pool, one record per cell of a sorted row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request transaction:
//   op_i selects allocate or free, req_size_i is the byte count of an
//   allocate, free_offset_i any pool offset inside the block to free.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   transaction per request: alloc_offset_o (zero unless an allocate
//   succeeded) and status_o.
//   Steps: after a request is accepted, every cell first tests its own gap
//   or range in parallel and registers its hit; then the prefix-OR scan
//   picks the first hit and the row shifts.
//   The input stays stalled through both steps, so only one request is in
//   flight at a time; the next request is taken once the block is idle again.
//   The input may accept a new request while a finished result still waits
//   in the output register; a stalled output holds the request in its final
//   step until the register frees up.
//   Reset: the table empties (all cells invalid, lengths zero, count zero)
//   and both channels go idle. No clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [ffpa_pkg::REQ_W-1:0]  req_size_i,
  input  logic [ffpa_pkg::OFF_W-1:0]  free_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ffpa_pkg::OFF_W-1:0]  alloc_offset_o,
  output logic [ffpa_pkg::STAT_W-1:0] status_o
);
  import ffpa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q;
  logic [SIZE_W-1:0] size_q;
  logic              zero_q;
  logic [OFF_W-1:0]  off_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [OFF_W-1:0]  out_off_q, out_off_d;
  status_e           out_stat_q, out_stat_d;

  logic              accept;
  logic              fire;
  logic              full;
  logic              ins_ok;
  logic              del_ok;
  logic [SIZE_W-1:0] size_rnd;
  ctl_t              ctl;

  rec_t [SLOTS-1:0]             recs;
  logic [SLOTS-1:0]             hits;
  logic [SLOTS-1:0][OFF_W-1:0]  bases;
  logic [SLOTS-1:0]             sel_le;
  logic [SLOTS-1:0]             sel_lt;
  logic                         found;
  logic [OFF_W-1:0]             base_sel;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // round the request up to a multiple of 4 without wrapping
  assign size_rnd = (SIZE_W'(req_size_i) + SIZE_W'(3)) & ~SIZE_W'(3);

  // advance out of the final step only when the output register can take it
  assign fire   = (state_q == S_APPLY) && (!out_valid_q || !out_stall_i);
  assign full   = (count_q == CNT_FULL);
  assign ins_ok = (op_q == OP_ALLOC) && !zero_q && !full && found;
  assign del_ok = (op_q == OP_FREE) && found;

  assign ctl = '{eval:    (state_q == S_EVAL),
                 is_free: (op_q == OP_FREE),
                 ins:     fire && ins_ok,
                 del:     fire && del_ok,
                 size:    size_q,
                 off:     off_q};

  // row of cells: each sees its left and right neighbor
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    rec_t left_rec;
    rec_t right_rec;
    if (i == 0) begin : g_first
      assign left_rec = REC_ORIGIN;
    end else begin : g_mid
      assign left_rec = recs[i-1];
    end
    if (i == SLOTS - 1) begin : g_last
      assign right_rec = REC_EMPTY;
    end else begin : g_inner
      assign right_rec = recs[i+1];
    end

    ffpa_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .left_i   (left_rec),
      .right_i  (right_rec),
      .sel_le_i (sel_le[i]),
      .sel_lt_i (sel_lt[i]),
      .rec_o    (recs[i]),
      .hit_o    (hits[i]),
      .base_o   (bases[i])
    );
  end

  ffpa_scan u_scan (
    .hit_i    (hits),
    .base_i   (bases),
    .sel_le_o (sel_le),
    .sel_lt_o (sel_lt),
    .found_o  (found),
    .base_o   (base_sel)
  );

  // result and next state
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_off_d   = out_off_q;
    out_stat_d  = out_stat_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (fire) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_off_d   = '0;
          if (op_q == OP_FREE) begin
            out_stat_d = found ? ST_OK : ST_NOT_FOUND;
            if (found) begin
              count_d = count_q - CNT_W'(1);
            end
          end else if (zero_q) begin
            out_stat_d = ST_ZERO;
          end else if (full) begin
            out_stat_d = ST_NO_SLOT;
          end else if (found) begin
            out_stat_d = ST_OK;
            out_off_d  = base_sel;
            count_d    = count_q + CNT_W'(1);
          end else begin
            out_stat_d = ST_NO_SPACE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_off_q   <= '0;
      out_stat_q  <= ST_OK;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_off_q   <= out_off_d;
      out_stat_q  <= out_stat_d;
    end
  end

  // hold the request for the duration of the transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(op_i);
      size_q <= size_rnd;
      zero_q <= (req_size_i == '0);
      off_q  <= free_offset_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign alloc_offset_o = out_off_q;
  assign status_o       = out_stat_q;

endmodule

// ===== rtl/core/ffpa_checker.sv =====
// ----------------------------------------------------------------------------
// ffpa_core_checker
// Port-level checks of the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
module ffpa_core_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [ffpa_pkg::OFF_W-1:0]  alloc_offset_o,
  input logic [ffpa_pkg::STAT_W-1:0] status_o
);
  import ffpa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(alloc_offset_o) && $stable(status_o)))
    else $error("stalled result changed");

  // one request in flight: the input closes right after an acceptance
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted a second request while busy");

  // failed requests report offset zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (alloc_offset_o == '0))
    else $error("nonzero offset on a failed request");

  // allocations are word aligned
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_OK)) |-> (alloc_offset_o[1:0] == 2'b00))
    else $error("unaligned allocation offset");

endmodule

bind first_fit_pool_allocator_core ffpa_core_checker u_ffpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .alloc_offset_o (alloc_offset_o),
  .status_o       (status_o)
);

// ===== tb/ffpa_checker.sv =====
// ----------------------------------------------------------------------------
// ffpa_checker
// Watches both channels of the pool allocator, predicts every result and
// compares it, field by field, with the result transaction that comes out.
// ----------------------------------------------------------------------------
module ffpa_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        op_i,
  input  logic [ffpa_pkg::REQ_W-1:0]  req_size_i,
  input  logic [ffpa_pkg::OFF_W-1:0]  free_offset_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [ffpa_pkg::OFF_W-1:0]  alloc_offset_i,
  input  logic [ffpa_pkg::STAT_W-1:0] status_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          results_o,
  output int                          peak_fill_o,
  output logic [4:0]                  status_seen_o
);
  import ffpa_pkg::*;

  localparam int SHOW_MAX = 10;

  typedef struct {
    logic [OFF_W-1:0] offset;
    status_e          status;
  } grant_t;

  // Shadow of the record table: entries below rec_used are valid.
  logic [OFF_W-1:0] rec_base [SLOTS];
  logic [LEN_W-1:0] rec_size [SLOTS];
  int unsigned      rec_used;

  grant_t grant_q[$];

  // First-fit search or record removal; updates the shadow table.
  function automatic grant_t serve_request(logic op, logic [REQ_W-1:0] req,
                                           logic [OFF_W-1:0] off);
    grant_t      g;
    int unsigned size;
    int unsigned base;
    int unsigned pos;
    int unsigned s;
    int unsigned e;
    int unsigned i;
    int unsigned k;
    bit          hit;
    g.offset = '0;
    g.status = ST_OK;
    hit      = 1'b0;
    base     = 0;
    pos      = rec_used;
    if (op == OP_ALLOC) begin
      if (req == '0) begin
        g.status = ST_ZERO;
      end else if (rec_used >= SLOTS) begin
        g.status = ST_NO_SLOT;
      end else begin
        size = (int'(req) + 3) & 32'hFFFF_FFFC;
        for (i = 0; i < rec_used && !hit; i++) begin
          s = rec_base[i];
          if (s >= base && s - base >= size) begin
            hit = 1'b1;
            pos = i;
          end else begin
            base = s + rec_size[i];
          end
        end
        if (!hit && (base > POOL_BYTES || size > POOL_BYTES - base)) begin
          g.status = ST_NO_SPACE;
        end else begin
          for (k = rec_used; k > pos; k--) begin
            rec_base[k] = rec_base[k-1];
            rec_size[k] = rec_size[k-1];
          end
          rec_base[pos] = OFF_W'(base);
          rec_size[pos] = LEN_W'(size);
          rec_used++;
          g.offset = OFF_W'(base);
        end
      end
    end else begin
      for (i = 0; i < rec_used && !hit; i++) begin
        s = rec_base[i];
        e = s + rec_size[i];
        if (s <= off && off < e) begin
          hit = 1'b1;
          pos = i;
        end
      end
      if (!hit) begin
        g.status = ST_NOT_FOUND;
      end else begin
        for (k = pos; k + 1 < rec_used; k++) begin
          rec_base[k] = rec_base[k+1];
          rec_size[k] = rec_size[k+1];
        end
        rec_used--;
        rec_base[rec_used] = '0;
        rec_size[rec_used] = '0;
      end
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t g;
    if (!rst_ni) begin
      rec_used = 0;
      grant_q.delete();
      fail_count_o  = 0;
      results_o     = 0;
      peak_fill_o   = 0;
      status_seen_o = '0;
      for (int i = 0; i < SLOTS; i++) begin
        rec_size[i] = '0;
      end
    end else begin
      // Compare first: a result never belongs to a request taken this edge.
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (status_i < 5) status_seen_o[status_i] = 1'b1;
        if (grant_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= SHOW_MAX)
            $display("[%0t] unexpected result: offset %0d status %0d",
                     $realtime, alloc_offset_i, status_i);
        end else begin
          g = grant_q.pop_front();
          if (alloc_offset_i !== g.offset || status_i !== g.status) begin
            fail_count_o++;
            if (fail_count_o <= SHOW_MAX)
              $display("[%0t] mismatch: expected offset %0d status %s, got offset %0d status %0d",
                       $realtime, g.offset, g.status.name(), alloc_offset_i, status_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        grant_q.push_back(serve_request(op_i, req_size_i, free_offset_i));
        if (rec_used > peak_fill_o) peak_fill_o = rec_used;
      end
    end
    pending_o = grant_q.size();
  end

endmodule

// ===== tb/first_fit_pool_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_core_tb
// Drives allocate and free transactions into the pool allocator with random
// gaps and output stalls; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_core_tb;
  import ffpa_pkg::*;

  localparam int WATCHDOG  = 2000;
  localparam int SETTLE    = 10;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic              op_i          = OP_ALLOC;
  logic [REQ_W-1:0]  req_size_i    = '0;
  logic [OFF_W-1:0]  free_offset_i = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [OFF_W-1:0]  alloc_offset_o;
  logic [STAT_W-1:0] status_o;

  int         fail_count;
  int         pending;
  int         results;
  int         peak_fill;
  logic [4:0] status_seen;

  // Knobs for the current phase: sender gaps and receiver stalls on or off.
  bit gaps_on  = 1'b0;
  bit stall_on = 1'b0;

  int sent_cnt = 0;
  int rcvd_cnt = 0;
  int idle_cnt = 0;
  int stall_left = 0;

  // Ops of requests in flight, in order, and offsets of live blocks as
  // reported by the block; frees pick their targets from the latter.
  logic             op_q[$];
  logic [OFF_W-1:0] live_offs[$];

  first_fit_pool_allocator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .req_size_i     (req_size_i),
    .free_offset_i  (free_offset_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alloc_offset_o (alloc_offset_o),
    .status_o       (status_o)
  );

  ffpa_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .op_i           (op_i),
    .req_size_i     (req_size_i),
    .free_offset_i  (free_offset_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alloc_offset_i (alloc_offset_o),
    .status_i       (status_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .peak_fill_o    (peak_fill),
    .status_seen_o  (status_seen)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: alternate open runs and stall runs; most stalls are short,
  // a few are long enough to back the request up into the input side.
  always @(posedge clk_i) begin
    if (!stall_on) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 60) begin
      out_stall_i <= 1'b0;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_stall_i <= 1'b1;
      stall_left  <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(10, 50);
    end
  end

  // Track result transactions: count them and harvest successful offsets.
  always @(posedge clk_i) begin
    logic op;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rcvd_cnt++;
      if (op_q.size() > 0) begin
        op = op_q.pop_front();
        if (op == OP_ALLOC && status_o == ST_OK) live_offs.push_back(alloc_offset_o);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WATCHDOG) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG);
        $display("FAIL first_fit_pool_allocator_core");
        $finish;
      end
    end
  end

  // Sender gap: mostly back to back, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Offset inside a live block, or any pool offset when none is known.
  function automatic logic [OFF_W-1:0] free_target();
    int idx;
    logic [OFF_W-1:0] off;
    if (live_offs.size() == 0) return OFF_W'($urandom);
    idx = $urandom_range(0, live_offs.size() - 1);
    off = live_offs[idx] + OFF_W'($urandom_range(0, 3));
    live_offs.delete(idx);
    return off;
  endfunction

  // Present one request transaction and hold it until the block takes it.
  task automatic send_req(input logic op, input logic [REQ_W-1:0] size,
                          input logic [OFF_W-1:0] off);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    req_size_i    <= size;
    free_offset_i <= off;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
    op_q.push_back(op);
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (rcvd_cnt != sent_cnt);
  endtask

  task automatic alloc_req(input logic [REQ_W-1:0] size);
    send_req(OP_ALLOC, size, OFF_W'($urandom));
  endtask

  task automatic free_req(input logic [OFF_W-1:0] off);
    send_req(OP_FREE, REQ_W'($urandom), off);
  endtask

  // One random request of the mixed phases; max_size bounds ordinary sizes.
  task automatic mixed_req(input int max_size);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      alloc_req(REQ_W'($urandom_range(1, max_size)));
    else if (r < 55) alloc_req(REQ_W'($urandom));
    else if (r < 58) alloc_req('0);
    else if (r < 88) free_req(free_target());
    else             free_req(OFF_W'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero size, rounding past the pool, exact fits, first-fit
    // into a gap, frees at block edges, misses, and ignored fields.
    alloc_req('0);
    alloc_req(16'hFFFF);
    alloc_req(16'hFFFD);
    alloc_req(REQ_W'(POOL_BYTES + 1));
    alloc_req(1);
    alloc_req(REQ_W'(POOL_BYTES));
    free_req(OFF_W'(POOL_BYTES - 1));
    send_req(OP_FREE, 16'hFFFF, 3);
    send_req(OP_ALLOC, REQ_W'(POOL_BYTES), OFF_W'(POOL_BYTES - 1));
    alloc_req(4);
    send_req(OP_FREE, 16'hFFFF, 1024);
    alloc_req(5);
    alloc_req(4);
    alloc_req(2);
    free_req(8);
    alloc_req(8);
    alloc_req(3);
    free_req(12);
    free_req(12);
    alloc_req(REQ_W'(POOL_BYTES - 24));
    alloc_req(4);
    alloc_req(4);
    free_req(OFF_W'(POOL_BYTES - 1));
    free_req(0);
    send_req(OP_FREE, '0, '0);

    // Hold off the sender until the block has answered everything.
    wait_drained();

    // Mixed traffic with small blocks under full idling on both sides.
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    repeat (100) mixed_req(64);

    // Fill the table with tiny blocks until record slots run out.
    stall_on = 1'b0;
    repeat (150) alloc_req(REQ_W'($urandom_range(1, 12)));
    wait_drained();

    // Drain: mostly frees of live blocks, some stray offsets.
    gaps_on  = 1'b0;
    stall_on = 1'b1;
    repeat (100) begin
      if ($urandom_range(0, 99) < 85) free_req(free_target());
      else free_req(OFF_W'($urandom));
    end

    // Mixed traffic with large blocks to exercise the no-space path.
    gaps_on = 1'b1;
    repeat (60) mixed_req(1024);

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);

    $display("covered %0d requests, %0d results, peak table fill %0d of %0d",
             sent_cnt, results, peak_fill, SLOTS);
    $display("status codes seen (bit per code): %05b, %0d mismatches, %0d left over",
             status_seen, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS first_fit_pool_allocator_core");
    end else begin
      $display("FAIL first_fit_pool_allocator_core");
    end
    $finish;
  end

endmodule
